FILE: rtl/scp_pkg.sv
// ============================================================================
// scp_pkg
// Shared types, character codes and response tables for the slcan command
// parser.
// ============================================================================
package scp_pkg;

  // Line store geometry
  localparam int LINE_LEN = 32;
  localparam int IDX_W    = $clog2(LINE_LEN);
  // Scan positions reach past the end of a full frame line (up to 26)
  localparam int POS_W    = (IDX_W + 1 > 5) ? IDX_W + 1 : 5;

  // Character codes
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_NACK = 8'h07;
  localparam logic [7:0] CH_Z    = "Z";
  localparam logic [7:0] CH_V    = "V";
  localparam logic [7:0] CH_N    = "N";
  localparam logic [7:0] CH_0    = "0";
  localparam logic [7:0] CH_1    = "1";
  localparam logic [7:0] CH_2    = "2";
  localparam logic [7:0] CH_8    = "8";

  // Command letters
  localparam logic [7:0] CMD_STD_DATA = "t";
  localparam logic [7:0] CMD_EXT_DATA = "T";
  localparam logic [7:0] CMD_STD_RTR  = "r";
  localparam logic [7:0] CMD_EXT_RTR  = "R";
  localparam logic [7:0] CMD_OPEN     = "O";
  localparam logic [7:0] CMD_CLOSE    = "C";
  localparam logic [7:0] CMD_TSTAMP   = "Z";
  localparam logic [7:0] CMD_CODE     = "M";
  localparam logic [7:0] CMD_MASK     = "m";
  localparam logic [7:0] CMD_SPEED    = "S";
  localparam logic [7:0] CMD_FLAGS    = "F";
  localparam logic [7:0] CMD_VERSION  = "V";
  localparam logic [7:0] CMD_SERIAL   = "N";
  localparam logic [7:0] CMD_LFEED    = "l";

  // Hex field scan state of the shared digit unit
  typedef struct packed {
    logic [31:0] acc;
    logic        stopped;
    logic [3:0]  found;
  } hex_st_t;

  // Response sequences
  typedef enum logic [2:0] {
    R_NACK  = 3'd0,
    R_ACK   = 3'd1,
    R_FRAME = 3'd2,
    R_VER   = 3'd3,
    R_SER   = 3'd4
  } resp_t;

  // Field being parsed
  typedef enum logic [1:0] {
    P_ID   = 2'd0,
    P_DLC  = 2'd1,
    P_DATA = 2'd2,
    P_WORD = 2'd3
  } phase_t;

  function automatic logic [2:0] resp_len(resp_t r);
    logic [2:0] n;
    case (r)
      R_NACK:  n = 3'd1;
      R_ACK:   n = 3'd2;
      R_FRAME: n = 3'd3;
      R_VER:   n = 3'd4;
      R_SER:   n = 3'd7;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Character of item i in a response; the frame slot yields zero
  function automatic logic [7:0] resp_char(resp_t r, logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    case (r)
      R_NACK: c = CH_NACK;
      R_ACK:  c = (i == 3'd0) ? CH_Z : CH_CR;
      R_FRAME: begin
        case (i)
          3'd1:    c = CH_Z;
          3'd2:    c = CH_CR;
          default: c = 8'h00;
        endcase
      end
      R_VER: begin
        case (i)
          3'd0:    c = CH_V;
          3'd1:    c = CH_1;
          3'd2:    c = CH_Z;
          default: c = CH_CR;
        endcase
      end
      R_SER: begin
        case (i)
          3'd0:    c = CH_N;
          3'd1:    c = CH_2;
          3'd2:    c = CH_2;
          3'd3:    c = CH_0;
          3'd4:    c = CH_8;
          3'd5:    c = CH_Z;
          default: c = CH_CR;
        endcase
      end
      default: c = CH_NACK;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/scp_if.sv
// ============================================================================
// scp_in_if / scp_out_if
// Valid/ready channels of the slcan command parser: received bytes in,
// response bytes and CAN frames out.
// ============================================================================
interface scp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       transmit_ok;

  modport source (output valid, output rx_byte, output transmit_ok, input ready);
  modport sink   (input valid, input rx_byte, input transmit_ok, output ready);
endinterface

interface scp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic [31:0] frame_id;
  logic        frame_extended;
  logic        frame_remote;
  logic [3:0]  frame_length;
  logic [63:0] frame_data;
  logic [2:0]  mode_flags;
  logic [3:0]  speed_index;
  logic [31:0] filter_code;
  logic [31:0] filter_mask;
  logic        last;

  modport source (
    output valid, output kind, output tx_byte, output frame_id,
    output frame_extended, output frame_remote, output frame_length,
    output frame_data, output mode_flags, output speed_index,
    output filter_code, output filter_mask, output last,
    input ready
  );
  modport sink (
    input valid, input kind, input tx_byte, input frame_id,
    input frame_extended, input frame_remote, input frame_length,
    input frame_data, input mode_flags, input speed_index,
    input filter_code, input filter_mask, input last,
    output ready
  );
endinterface

FILE: rtl/scp_line_store.sv
// ============================================================================
// scp_line_store
// Line buffer: one write port for received bytes, one registered read port
// for the line scan.
// ============================================================================
module scp_line_store (
  input  logic                     clk,
  input  logic                     we,
  input  logic [scp_pkg::IDX_W-1:0] waddr,
  input  logic [7:0]               wdata,
  input  logic [scp_pkg::IDX_W-1:0] raddr,
  output logic [7:0]               rdata
);
  import scp_pkg::*;

  logic [7:0] mem [LINE_LEN];

  // Write received byte
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/scp_hex_unit.sv
// ============================================================================
// scp_hex_unit
// Shared digit unit: decodes one character and shifts it into the field
// accumulator unless the field has already stopped or the character is not hex.
// ============================================================================
module scp_hex_unit (
  input  logic [7:0]       ch,
  input  scp_pkg::hex_st_t st,
  output scp_pkg::hex_st_t st_next
);
  import scp_pkg::*;

  logic       is_hex;
  logic [3:0] digit;

  // Hex decode, either case
  always_comb begin
    is_hex = 1'b1;
    digit  = 4'd0;
    if (ch >= "0" && ch <= "9") begin
      digit = 4'(ch - "0");
    end else if (ch >= "A" && ch <= "F") begin
      digit = 4'(ch - "A" + 8'd10);
    end else if (ch >= "a" && ch <= "f") begin
      digit = 4'(ch - "a" + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Shift in, or stop at the first non-hex byte
  always_comb begin
    st_next = st;
    if (!st.stopped && is_hex) begin
      st_next.acc   = {st.acc[27:0], digit};
      st_next.found = st.found + 4'd1;
    end else begin
      st_next.stopped = 1'b1;
    end
  end

endmodule

FILE: rtl/slcan_command_parser.sv
// ============================================================================
// slcan_command_parser
// Lawicel ASCII command parser: line buffer, hex field scan and responses.
// ============================================================================
// Usage:
//   rx carries one serial byte per transfer with the transmit_ok flag of the
//   CAN controller. Bytes are stored in a 32-byte line buffer; a plain byte
//   gives no result and the block is ready again the next cycle.
//   A carriage return starts a scan of the line, one stored character per
//   cycle through the single read port and the shared hex digit unit. The
//   scan stops once the command is decided; an extended frame with 8 data
//   bytes takes the longest. Results, if any, then leave on res, one per
//   transfer, 1 to 7 of them, with last set on the final one; a CAN frame
//   result precedes its "Z\r" ack. A line that fills the buffer gives one
//   nack and is dropped. rx.ready is low from the carriage return or the
//   filling byte until the last result has been loaded into the output
//   register, or the scan has ended with no result; a stall on res holds
//   the block there, the held result staying stable.
//   Reset (synchronous, rst high) empties the line, opens the bus, clears
//   timestamps, line feed and speed, sets code 0 and mask all ones.
//   Buffer contents are not cleared; only bytes of the current line are read.
// ============================================================================
module slcan_command_parser (
  input  logic clk,
  input  logic rst,
  scp_in_if.sink    rx,
  scp_out_if.source res
);
  import scp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  logic [IDX_W-1:0] line_index;
  logic [POS_W-1:0] line_len;
  logic             tok;
  logic             bus_open, ts_on, lf_on;
  logic [3:0]       speed;
  logic [31:0]      code_w, mask_w;

  logic [POS_W-1:0] fetch_pos, proc_pos;
  logic             proc_valid;
  logic [7:0]       cmd;
  logic             ext, rtr;
  phase_t           phase;
  logic [3:0]       field_left;
  hex_st_t          hs, hn;
  logic [31:0]      frame_id;
  logic [3:0]       dlc;
  logic [7:0][7:0]  data;
  logic [2:0]       byte_i;
  resp_t            resp;
  logic [2:0]       eidx;

  logic [7:0] rdata, ch;
  logic       accept, load, is_last, last_byte;

  assign rx.ready = (state == ST_IDLE);
  assign accept   = rx.valid && rx.ready;
  assign last_byte = (line_index == IDX_W'(LINE_LEN - 1));

  scp_line_store u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (line_index),
    .wdata (rx.rx_byte),
    .raddr (fetch_pos[IDX_W-1:0]),
    .rdata (rdata)
  );

  // Bytes at or past the line end read as zero (non-hex)
  assign ch = (proc_pos < line_len) ? rdata : 8'h00;

  scp_hex_unit u_hex (
    .ch      (ch),
    .st      (hs),
    .st_next (hn)
  );

  assign load    = (state == ST_EMIT) && (!res.valid || res.ready);
  assign is_last = (eidx == resp_len(resp) - 3'd1);

  // Sequencer: receive, scan, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_index <= '0;
      bus_open   <= 1'b1;
      ts_on      <= 1'b0;
      lf_on      <= 1'b0;
      speed      <= 4'd0;
      code_w     <= 32'h0;
      mask_w     <= 32'hFFFF_FFFF;
      proc_valid <= 1'b0;
      eidx       <= 3'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            tok <= rx.transmit_ok;
            if (last_byte) begin
              line_index <= '0;
              resp       <= R_NACK;
              eidx       <= 3'd0;
              state      <= ST_EMIT;
            end else if (rx.rx_byte == CH_CR) begin
              line_len   <= POS_W'(line_index) + POS_W'(1);
              line_index <= '0;
              fetch_pos  <= '0;
              proc_valid <= 1'b0;
              data       <= '0;
              eidx       <= 3'd0;
              state      <= ST_SCAN;
            end else begin
              line_index <= line_index + IDX_W'(1);
            end
          end
        end

        ST_SCAN: begin
          fetch_pos  <= fetch_pos + POS_W'(1);
          proc_pos   <= fetch_pos;
          proc_valid <= 1'b1;
          if (proc_valid) begin
            if (proc_pos == '0) begin
              // Command letter
              cmd        <= ch;
              hs         <= '0;
              phase      <= P_ID;
              ext        <= (ch == CMD_EXT_DATA) || (ch == CMD_EXT_RTR);
              rtr        <= (ch == CMD_STD_RTR) || (ch == CMD_EXT_RTR);
              field_left <= ((ch == CMD_EXT_DATA) || (ch == CMD_EXT_RTR)) ? 4'd8 : 4'd3;
              unique case (ch)
                CMD_STD_DATA, CMD_EXT_DATA, CMD_STD_RTR, CMD_EXT_RTR: begin
                  if (!bus_open) begin
                    resp  <= R_NACK;
                    state <= ST_EMIT;
                  end
                end
                CMD_CODE, CMD_MASK: begin
                  field_left <= 4'd8;
                  phase      <= P_WORD;
                end
                CMD_OPEN:    begin bus_open <= 1'b1; resp <= R_ACK; state <= ST_EMIT; end
                CMD_CLOSE:   begin bus_open <= 1'b0; resp <= R_ACK; state <= ST_EMIT; end
                CMD_FLAGS:   begin resp <= R_ACK; state <= ST_EMIT; end
                CMD_VERSION: begin resp <= R_VER; state <= ST_EMIT; end
                CMD_SERIAL:  begin resp <= R_SER; state <= ST_EMIT; end
                CMD_LFEED:   begin lf_on <= !lf_on; resp <= R_NACK; state <= ST_EMIT; end
                CMD_TSTAMP, CMD_SPEED: ;
                default:     begin resp <= R_NACK; state <= ST_EMIT; end
              endcase
            end else if (cmd == CMD_TSTAMP) begin
              // Timestamp switch; other arguments give no response
              if (ch == CH_0) begin
                ts_on <= 1'b0; resp <= R_ACK; state <= ST_EMIT;
              end else if (ch == CH_1) begin
                ts_on <= 1'b1; resp <= R_ACK; state <= ST_EMIT;
              end else begin
                state <= ST_IDLE;
              end
            end else if (cmd == CMD_SPEED) begin
              // Bit rate, only while closed
              if (bus_open) begin
                state <= ST_IDLE;
              end else if (ch >= CH_0 && ch <= CH_8) begin
                speed <= 4'(ch - CH_0); resp <= R_ACK; state <= ST_EMIT;
              end else begin
                resp <= R_NACK; state <= ST_EMIT;
              end
            end else begin
              // Hex field step through the shared unit
              hs         <= hn;
              field_left <= field_left - 4'd1;
              if (field_left == 4'd1) begin
                hs <= '0;
                case (phase)
                  P_WORD: begin
                    if (!bus_open && hn.found != 4'd0) begin
                      if (cmd == CMD_CODE) code_w <= hn.acc;
                      else mask_w <= hn.acc;
                    end
                    resp  <= R_ACK;
                    state <= ST_EMIT;
                  end
                  P_ID: begin
                    frame_id   <= hn.acc;
                    phase      <= P_DLC;
                    field_left <= 4'd1;
                  end
                  P_DLC: begin
                    dlc <= hn.acc[3:0];
                    if (hn.acc[3:0] > 4'd8) begin
                      resp  <= R_NACK;
                      state <= ST_EMIT;
                    end else if (rtr || hn.acc[3:0] == 4'd0) begin
                      resp  <= tok ? R_FRAME : R_NACK;
                      state <= ST_EMIT;
                    end else begin
                      phase      <= P_DATA;
                      byte_i     <= 3'd0;
                      field_left <= 4'd2;
                    end
                  end
                  default: begin
                    data[byte_i] <= hn.acc[7:0];
                    if ({1'b0, byte_i} + 4'd1 == dlc) begin
                      resp  <= tok ? R_FRAME : R_NACK;
                      state <= ST_EMIT;
                    end else begin
                      byte_i     <= byte_i + 3'd1;
                      field_left <= 4'd2;
                    end
                  end
                endcase
              end
            end
          end
        end

        ST_EMIT: begin
          if (load) begin
            if (is_last) begin
              eidx  <= 3'd0;
              state <= ST_IDLE;
            end else begin
              eidx <= eidx + 3'd1;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.kind        <= (resp == R_FRAME) && (eidx == 3'd0);
      res.tx_byte     <= resp_char(resp, eidx);
      res.mode_flags  <= {lf_on, ts_on, bus_open};
      res.speed_index <= speed;
      res.filter_code <= code_w;
      res.filter_mask <= mask_w;
      res.last        <= is_last;
      if ((resp == R_FRAME) && (eidx == 3'd0)) begin
        res.frame_id       <= frame_id;
        res.frame_extended <= ext;
        res.frame_remote   <= rtr;
        res.frame_length   <= dlc;
        res.frame_data     <= rtr ? 64'h0 : data;
      end else begin
        res.frame_id       <= 32'h0;
        res.frame_extended <= 1'b0;
        res.frame_remote   <= 1'b0;
        res.frame_length   <= 4'd0;
        res.frame_data     <= 64'h0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_emit_idx: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> eidx < resp_len(resp))
    else $error("response index past sequence end");
  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> line_len != '0)
    else $error("scan of an empty line");
  a_frame_len: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind |-> res.frame_length <= 4'd8 && res.mode_flags[0])
    else $error("frame emitted with bad length or closed bus");
  a_frame_ack: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.kind |-> !res.last)
    else $error("frame result marked last");
`endif

endmodule
